// ===== design/tmfn_pkg.sv =====
package tmfn_pkg;

  // Fixed-point format of every Q value in the block.
  localparam int FRAC_BITS = 16;

  // Field widths.
  localparam int IN_W  = 32;
  localparam int OUT_W = 32;
  localparam int NRM_W = 18;

  // Divider: numerator and denominator magnitudes, partial remainder, quotient.
  localparam int DEN_W     = 34;
  localparam int REM_W     = FRAC_BITS + 36;
  localparam int Q_W       = 32;
  localparam int DIV_STEPS = Q_W;
  localparam int DIV_LAT   = DIV_STEPS + 1;

  // Square root: radicand, partial remainder and root widths.
  localparam int RAD_W      = 66;
  localparam int SQ_REM_W   = 37;
  localparam int ROOT_W     = 34;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int SQRT_LAT   = SQRT_STEPS + 2;

  // Cycles from an accepted item to its result strobe: three front stages,
  // the square root, the dividers and the output stage.
  localparam int LATENCY = 4 + SQRT_LAT + DIV_LAT;

  // Face codes; any other code selects the first face.
  localparam logic [1:0] FACE_SECOND = 2'd1;
  localparam logic [1:0] FACE_THIRD  = 2'd2;

  // Status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZERO_J = 2'd1,
    ST_ZERO_N = 2'd2
  } status_t;

  // Side information that travels with an item alongside the arithmetic units.
  typedef struct packed {
    logic signed [OUT_W-1:0] jq;
    logic [OUT_W-1:0]        jqm;
    logic                    jz;
    logic                    nz;
    logic [IN_W-1:0]         m_ys;
    logic [IN_W-1:0]         m_yr;
    logic [IN_W-1:0]         m_xs;
    logic [IN_W-1:0]         m_xr;
    logic [IN_W-1:0]         mx;
    logic [IN_W-1:0]         my;
    logic                    neg_rx;
    logic                    neg_ry;
    logic                    neg_sx;
    logic                    neg_sy;
    logic                    neg_nx;
    logic                    neg_ny;
    logic                    last;
  } side_t;

  // Applies a sign to a clamped quotient and saturates to the 32-bit range.
  function automatic logic [OUT_W-1:0] sat_out(input logic [Q_W-1:0] q, input logic neg);
    logic [OUT_W-1:0] r;
    if (neg) begin
      r = q[Q_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'({Q_W{1'b0}} - q);
    end else begin
      r = q[Q_W-1] ? {1'b0, {(OUT_W-1){1'b1}}} : OUT_W'(q);
    end
    return r;
  endfunction

  // Applies a sign to a clamped quotient and saturates to the normal range.
  function automatic logic [NRM_W-1:0] sat_nrm(input logic [Q_W-1:0] q, input logic neg);
    logic [NRM_W-1:0] r;
    logic             big;
    big = |q[Q_W-1:NRM_W-1];
    if (neg) begin
      r = big ? {1'b1, {(NRM_W-1){1'b0}}} : NRM_W'({NRM_W{1'b0}} - q[NRM_W-1:0]);
    end else begin
      r = big ? {1'b0, {(NRM_W-1){1'b1}}} : q[NRM_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/tmfn_div.sv =====
// Pipelined restoring divider: rounded quotient of num scaled by the fraction
// bits over den. A quotient that reaches the top bit is clamped there.
module tmfn_div (
  input  logic                          clk,
  input  logic [tmfn_pkg::DEN_W-1:0]    num,
  input  logic [tmfn_pkg::DEN_W-1:0]    den,
  output logic [tmfn_pkg::Q_W-1:0]      quot
);

  logic [tmfn_pkg::REM_W-1:0] rem      [0:tmfn_pkg::DIV_STEPS];
  logic [tmfn_pkg::DEN_W-1:0] dv       [0:tmfn_pkg::DIV_STEPS];
  logic [tmfn_pkg::Q_W-1:0]   qv       [0:tmfn_pkg::DIV_STEPS];
  logic [tmfn_pkg::REM_W-1:0] rem_next [0:tmfn_pkg::DIV_STEPS-1];
  logic [tmfn_pkg::DIV_STEPS-1:0] ge;

  // Each stage tries one quotient bit, from the top bit down.
  always_comb begin
    for (int k = 0; k < tmfn_pkg::DIV_STEPS; k++) begin
      ge[k] = (rem[k] >> (tmfn_pkg::DIV_STEPS - 1 - k)) >= tmfn_pkg::REM_W'(dv[k]);
      rem_next[k] = ge[k]
        ? rem[k] - (tmfn_pkg::REM_W'(dv[k]) << (tmfn_pkg::DIV_STEPS - 1 - k))
        : rem[k];
    end
  end

  // Entry stage adds half the divisor for rounding; then one bit a stage.
  always_ff @(posedge clk) begin
    rem[0] <= (tmfn_pkg::REM_W'(num) << tmfn_pkg::FRAC_BITS)
              + tmfn_pkg::REM_W'(den >> 1);
    dv[0]  <= den;
    qv[0]  <= '0;
    for (int k = 0; k < tmfn_pkg::DIV_STEPS; k++) begin
      rem[k+1] <= rem_next[k];
      dv[k+1]  <= dv[k];
      qv[k+1]  <= {qv[k][tmfn_pkg::Q_W-2:0], ge[k]};
    end
  end

  // A set top bit means the quotient is at or past the saturation limit.
  assign quot = qv[tmfn_pkg::DIV_STEPS][tmfn_pkg::Q_W-1]
              ? {1'b1, {(tmfn_pkg::Q_W-1){1'b0}}}
              : qv[tmfn_pkg::DIV_STEPS];

endmodule

// ===== design/tmfn_sqrt.sv =====
// Pipelined digit-by-digit square root with round to nearest.
module tmfn_sqrt (
  input  logic                          clk,
  input  logic [tmfn_pkg::RAD_W-1:0]    rad_in,
  output logic [tmfn_pkg::ROOT_W-1:0]   root_out
);

  logic [tmfn_pkg::RAD_W-1:0]    rad       [0:tmfn_pkg::SQRT_STEPS];
  logic [tmfn_pkg::SQ_REM_W-1:0] rem       [0:tmfn_pkg::SQRT_STEPS];
  logic [tmfn_pkg::ROOT_W-1:0]   root      [0:tmfn_pkg::SQRT_STEPS];
  logic [tmfn_pkg::SQ_REM_W-1:0] rem_next  [0:tmfn_pkg::SQRT_STEPS-1];
  logic [tmfn_pkg::SQRT_STEPS-1:0] ge;

  // Each stage brings down one pair of radicand bits and tries one root bit.
  always_comb begin
    logic [tmfn_pkg::SQ_REM_W-1:0] shifted;
    logic [tmfn_pkg::SQ_REM_W-1:0] trial;
    for (int k = 0; k < tmfn_pkg::SQRT_STEPS; k++) begin
      shifted = {rem[k][tmfn_pkg::SQ_REM_W-3:0],
                 rad[k][tmfn_pkg::RAD_W-1:tmfn_pkg::RAD_W-2]};
      trial   = tmfn_pkg::SQ_REM_W'({root[k], 2'b01});
      ge[k]   = shifted >= trial;
      rem_next[k] = ge[k] ? shifted - trial : shifted;
    end
  end

  always_ff @(posedge clk) begin
    rad[0]  <= rad_in;
    rem[0]  <= '0;
    root[0] <= '0;
    for (int k = 0; k < tmfn_pkg::SQRT_STEPS; k++) begin
      rad[k+1]  <= rad[k] << 2;
      rem[k+1]  <= rem_next[k];
      root[k+1] <= {root[k][tmfn_pkg::ROOT_W-2:0], ge[k]};
    end
    // Round up when the remainder exceeds the truncated root.
    root_out <= (rem[tmfn_pkg::SQRT_STEPS]
                 > tmfn_pkg::SQ_REM_W'(root[tmfn_pkg::SQRT_STEPS]))
              ? root[tmfn_pkg::SQRT_STEPS] + tmfn_pkg::ROOT_W'(1)
              : root[tmfn_pkg::SQRT_STEPS];
  end

endmodule

// ===== design/triangle_metric_and_face_normal_unit.sv =====
// Geometric factors for one node of a straight-sided triangle.
// An item is the node's mapping derivatives, a face code and a last-node mark;
// it is taken at a clock edge with start high and busy low. busy is always low:
// the unit is fully pipelined and takes one item every cycle.
// Each item yields one result, shown for one cycle with done high: the
// Jacobian, the four inverse metric terms, the unit outward normal of the
// chosen face, the face scale, a status code and the copied last mark.
// The result is formed in the multiply and add stages, the square root pipeline
// that forms the normal length, the seven parallel divider pipelines and one
// output stage, in that order.
// Results leave in the order that items arrived. The receiver cannot stall,
// so no result is ever held back. A synchronous reset clears all valid bits;
// items in flight are dropped and no result appears until new items arrive.
module triangle_metric_and_face_normal_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [tmfn_pkg::IN_W-1:0]    metric_xr,
  input  logic signed [tmfn_pkg::IN_W-1:0]    metric_yr,
  input  logic signed [tmfn_pkg::IN_W-1:0]    metric_xs,
  input  logic signed [tmfn_pkg::IN_W-1:0]    metric_ys,
  input  logic [1:0]                          face,
  input  logic                                last_node,
  output logic                                done,
  output logic signed [tmfn_pkg::OUT_W-1:0]   jacobian,
  output logic signed [tmfn_pkg::OUT_W-1:0]   inv_rx,
  output logic signed [tmfn_pkg::OUT_W-1:0]   inv_ry,
  output logic signed [tmfn_pkg::OUT_W-1:0]   inv_sx,
  output logic signed [tmfn_pkg::OUT_W-1:0]   inv_sy,
  output logic signed [tmfn_pkg::NRM_W-1:0]   normal_x,
  output logic signed [tmfn_pkg::NRM_W-1:0]   normal_y,
  output logic signed [tmfn_pkg::OUT_W-1:0]   face_scale,
  output logic [1:0]                          status,
  output logic                                last_out
);

  localparam int LAST = tmfn_pkg::SQRT_LAT + tmfn_pkg::DIV_LAT;

  logic                     v1, v2;
  logic                     vld [0:LAST];
  tmfn_pkg::side_t          sd1, sd2;
  tmfn_pkg::side_t          pipe [0:LAST];
  tmfn_pkg::side_t          sd1_next;
  tmfn_pkg::side_t          sd2_next;
  tmfn_pkg::side_t          pipe0_next;
  logic signed [63:0]       p1, p2;
  logic [63:0]              sq_x, sq_y;
  logic [tmfn_pkg::RAD_W-1:0] rad;
  logic signed [32:0]       nx, ny;
  logic signed [64:0]       jf;
  logic [64:0]              jfm, jm;
  logic signed [tmfn_pkg::OUT_W-1:0] jq_next;
  logic [tmfn_pkg::ROOT_W-1:0] js;
  logic [tmfn_pkg::Q_W-1:0] q_rx, q_ry, q_sx, q_sy, q_nx, q_ny, q_fs;
  tmfn_pkg::side_t          po;

  assign busy = 1'b0;

  // Stage one: face normal selection, input magnitudes and signs, and the two Jacobian products.
  always_comb begin
    case (face)
      tmfn_pkg::FACE_SECOND: begin
        nx = {metric_ys[31], metric_ys} - {metric_yr[31], metric_yr};
        ny = {metric_xr[31], metric_xr} - {metric_xs[31], metric_xs};
      end
      tmfn_pkg::FACE_THIRD: begin
        nx = 33'sd0 - {metric_ys[31], metric_ys};
        ny = {metric_xs[31], metric_xs};
      end
      default: begin
        nx = {metric_yr[31], metric_yr};
        ny = 33'sd0 - {metric_xr[31], metric_xr};
      end
    endcase
    sd1_next        = '0;
    sd1_next.m_ys   = metric_ys[31] ? 32'(32'd0 - metric_ys) : metric_ys;
    sd1_next.m_yr   = metric_yr[31] ? 32'(32'd0 - metric_yr) : metric_yr;
    sd1_next.m_xs   = metric_xs[31] ? 32'(32'd0 - metric_xs) : metric_xs;
    sd1_next.m_xr   = metric_xr[31] ? 32'(32'd0 - metric_xr) : metric_xr;
    sd1_next.mx     = nx[32] ? 32'(33'd0 - nx) : nx[31:0];
    sd1_next.my     = ny[32] ? 32'(33'd0 - ny) : ny[31:0];
    sd1_next.neg_rx = metric_ys[31];
    sd1_next.neg_ry = !metric_yr[31] && (metric_yr != '0);
    sd1_next.neg_sx = !metric_xs[31] && (metric_xs != '0);
    sd1_next.neg_sy = metric_xr[31];
    sd1_next.neg_nx = nx[32];
    sd1_next.neg_ny = ny[32];
    sd1_next.last   = last_node;
  end

  always_ff @(posedge clk) begin
    p1  <= metric_xr * metric_ys;
    p2  <= metric_yr * metric_xs;
    sd1 <= sd1_next;
  end

  // Stage two: the Jacobian is rounded and saturated; the normal is squared.
  always_comb begin
    jf  = {p1[63], p1} - {p2[63], p2};
    jfm = jf[64] ? 65'd0 - jf : jf;
    jm  = (jfm + (65'd1 << (tmfn_pkg::FRAC_BITS - 1))) >> tmfn_pkg::FRAC_BITS;
    if (jf[64]) begin
      jq_next = (jm >= 65'h8000_0000) ? 32'sh8000_0000 : 32'(65'd0 - jm);
    end else begin
      jq_next = (jm >= 65'h8000_0000) ? 32'sh7fff_ffff : jm[31:0];
    end
    sd2_next    = sd1;
    sd2_next.jq = jq_next;
    sd2_next.jz = (jm == 65'd0);
    sd2_next.nz = (sd1.mx == '0) && (sd1.my == '0);
  end

  always_ff @(posedge clk) begin
    sq_x <= sd1.mx * sd1.mx;
    sq_y <= sd1.my * sd1.my;
    sd2  <= sd2_next;
  end

  // Stage three: radicand of the normal length, Jacobian magnitude.
  always_comb begin
    pipe0_next     = sd2;
    pipe0_next.jqm = sd2.jq[31] ? 32'(32'd0 - sd2.jq) : sd2.jq;
  end

  always_ff @(posedge clk) begin
    rad     <= {1'b0, 65'(sq_x) + 65'(sq_y)};
    pipe[0] <= pipe0_next;
    for (int k = 1; k <= LAST; k++) begin
      pipe[k] <= pipe[k-1];
    end
  end

  // Valid bits run beside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      for (int k = 0; k <= LAST; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      v1     <= start && !busy;
      v2     <= v1;
      vld[0] <= v2;
      for (int k = 1; k <= LAST; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // Normal length.
  tmfn_sqrt u_sqrt (
    .clk      (clk),
    .rad_in   (rad),
    .root_out (js)
  );

  // Seven dividers run side by side once the normal length is known.
  tmfn_div u_div_rx (.clk(clk), .num(tmfn_pkg::DEN_W'(pipe[tmfn_pkg::SQRT_LAT].m_ys)),
    .den(tmfn_pkg::DEN_W'(pipe[tmfn_pkg::SQRT_LAT].jqm)), .quot(q_rx));
  tmfn_div u_div_ry (.clk(clk), .num(tmfn_pkg::DEN_W'(pipe[tmfn_pkg::SQRT_LAT].m_yr)),
    .den(tmfn_pkg::DEN_W'(pipe[tmfn_pkg::SQRT_LAT].jqm)), .quot(q_ry));
  tmfn_div u_div_sx (.clk(clk), .num(tmfn_pkg::DEN_W'(pipe[tmfn_pkg::SQRT_LAT].m_xs)),
    .den(tmfn_pkg::DEN_W'(pipe[tmfn_pkg::SQRT_LAT].jqm)), .quot(q_sx));
  tmfn_div u_div_sy (.clk(clk), .num(tmfn_pkg::DEN_W'(pipe[tmfn_pkg::SQRT_LAT].m_xr)),
    .den(tmfn_pkg::DEN_W'(pipe[tmfn_pkg::SQRT_LAT].jqm)), .quot(q_sy));
  tmfn_div u_div_nx (.clk(clk), .num(tmfn_pkg::DEN_W'(pipe[tmfn_pkg::SQRT_LAT].mx)),
    .den(js), .quot(q_nx));
  tmfn_div u_div_ny (.clk(clk), .num(tmfn_pkg::DEN_W'(pipe[tmfn_pkg::SQRT_LAT].my)),
    .den(js), .quot(q_ny));
  tmfn_div u_div_fs (.clk(clk), .num(js),
    .den(tmfn_pkg::DEN_W'(pipe[tmfn_pkg::SQRT_LAT].jqm)), .quot(q_fs));

  assign po = pipe[LAST];

  // Output stage: signs, saturation and the zero cases.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAST];
    end
    jacobian   <= po.jq;
    inv_rx     <= po.jz ? '0 : tmfn_pkg::sat_out(q_rx, po.neg_rx ^ po.jq[31]);
    inv_ry     <= po.jz ? '0 : tmfn_pkg::sat_out(q_ry, po.neg_ry ^ po.jq[31]);
    inv_sx     <= po.jz ? '0 : tmfn_pkg::sat_out(q_sx, po.neg_sx ^ po.jq[31]);
    inv_sy     <= po.jz ? '0 : tmfn_pkg::sat_out(q_sy, po.neg_sy ^ po.jq[31]);
    normal_x   <= po.nz ? '0 : tmfn_pkg::sat_nrm(q_nx, po.neg_nx);
    normal_y   <= po.nz ? '0 : tmfn_pkg::sat_nrm(q_ny, po.neg_ny);
    face_scale <= (po.jz || po.nz) ? '0 : tmfn_pkg::sat_out(q_fs, po.jq[31]);
    if (po.jz) begin
      status <= tmfn_pkg::ST_ZERO_J;
    end else if (po.nz) begin
      status <= tmfn_pkg::ST_ZERO_N;
    end else begin
      status <= tmfn_pkg::ST_OK;
    end
    last_out <= po.last;
  end

  // Every accepted item gives its result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(tmfn_pkg::LATENCY) done)
    else $error("result strobe missing after fixed latency");

  // A zero Jacobian clears the Jacobian-dependent fields.
  a_zero_j: assert property (@(posedge clk) disable iff (rst)
    done && status == tmfn_pkg::ST_ZERO_J |->
      jacobian == '0 && inv_rx == '0 && inv_sy == '0 && face_scale == '0)
    else $error("zero Jacobian result carries nonzero terms");

  // A zero-length normal clears the normal and the face scale.
  a_zero_n: assert property (@(posedge clk) disable iff (rst)
    done && status == tmfn_pkg::ST_ZERO_N |->
      normal_x == '0 && normal_y == '0 && face_scale == '0)
    else $error("zero normal result carries nonzero terms");

  // A good result has a nonzero Jacobian and a nonzero unit normal.
  a_ok: assert property (@(posedge clk) disable iff (rst)
    done && status == tmfn_pkg::ST_OK |->
      jacobian != '0 && (normal_x != '0 || normal_y != '0))
    else $error("good status with a degenerate result");

endmodule
